### hdl/kmcd_pkg.sv
// Shared constants and types for the key matrix change detector.
`timescale 1ns / 1ps

package kmcd_pkg;

    // Default matrix geometry.
    localparam int DEF_ROWS = 8;
    localparam int DEF_COLS = 16;

    // Number of column level bits carried by one input item.
    localparam int LEVEL_BITS = 16;

    // Field widths of the item payloads.
    localparam int ROW_W = 3;
    localparam int COL_W = 4;

    // Configuration register indexes (byte address = 4 * index).
    localparam logic [1:0] REG_PRESSED_LEVEL     = 2'd0;
    localparam logic [1:0] REG_KEYBOARD_SIDE     = 2'd1;
    localparam logic [1:0] REG_PRESS_EVENTS_ON   = 2'd2;
    localparam logic [1:0] REG_RELEASE_EVENTS_ON = 2'd3;

    // Settings that every column lane needs to classify a change.
    typedef struct packed {
        logic pressed_level;
        logic press_on;
        logic release_on;
    } kmcd_lane_ctrl_t;

endpackage

### hdl/key_matrix_change_detector.sv
// Top level of the key matrix change detector.
`timescale 1ns / 1ps

// A row sample enters on the slave stream: row index and column levels in
// s_tdata, and a prime flag in s_tuser. The block compares the levels with
// the ones it last stored for that row, one column lane per column, and
// stores the new levels. Every changed column whose kind (press or release)
// is enabled produces one event item on the master stream, in ascending
// column order, with tlast on the final event of the sample. A primed
// sample, or a sample for a row at or beyond ROWS, produces no events.
// Column bits at or above COLS are ignored. Events leave the merging stage one
// per cycle while the consumer is ready, and m_tready low holds them; the next
// sample is accepted as soon as the merging stage has handed its last event
// to the output register. Configuration is to be written through the APB
// port only while the block is idle; the block itself does not enforce it.
module key_matrix_change_detector
    import kmcd_pkg::*;
#(
    parameter int ROWS = DEF_ROWS,
    parameter int COLS = DEF_COLS
)
(
    input  logic        clk,
    input  logic        rst_n,

    // Row sample input.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // row_index[2:0], column_levels[18:3], zero fill
    input  logic        s_tuser,   // prime

    // Event output.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // event_row[2:0], event_column[6:3], event_side[7]
    output logic        m_tuser,   // is_press
    output logic        m_tlast,   // last_event

    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // Only as many column lanes as the input carries level bits.
    localparam int LANES = (COLS < LEVEL_BITS) ? COLS : LEVEL_BITS;

    // Configuration registers.
    logic pressed_level_reg;
    logic pressed_level_next;
    logic side_reg;
    logic side_next;
    logic press_on_reg;
    logic press_on_next;
    logic release_on_reg;
    logic release_on_next;

    logic       cfg_write;
    logic [1:0] cfg_index;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_index = paddr[3:2];

    always_comb
    begin
        pressed_level_next = pressed_level_reg;
        side_next          = side_reg;
        press_on_next      = press_on_reg;
        release_on_next    = release_on_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                REG_PRESSED_LEVEL:     pressed_level_next = pwdata[0];
                REG_KEYBOARD_SIDE:     side_next          = pwdata[0];
                REG_PRESS_EVENTS_ON:   press_on_next      = pwdata[0];
                REG_RELEASE_EVENTS_ON: release_on_next    = pwdata[0];
                default:               ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_index)
            REG_PRESSED_LEVEL:     prdata = {31'd0, pressed_level_reg};
            REG_KEYBOARD_SIDE:     prdata = {31'd0, side_reg};
            REG_PRESS_EVENTS_ON:   prdata = {31'd0, press_on_reg};
            REG_RELEASE_EVENTS_ON: prdata = {31'd0, release_on_reg};
            default:               prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pressed_level_reg <= 1'b0;
            side_reg          <= 1'b0;
            press_on_reg      <= 1'b0;
            release_on_reg    <= 1'b0;
        end
        else
        begin
            pressed_level_reg <= pressed_level_next;
            side_reg          <= side_next;
            press_on_reg      <= press_on_next;
            release_on_reg    <= release_on_next;
        end
    end

    // Input fields.
    logic [ROW_W-1:0] row_index;
    logic [LANES-1:0] now_levels;
    logic             prime;
    logic             accept;
    logic             row_ok;
    logic             busy;

    assign row_index  = s_tdata[ROW_W-1:0];
    assign now_levels = s_tdata[ROW_W +: LANES];
    assign prime      = s_tuser;
    assign s_tready   = !busy;
    assign accept     = s_tvalid && s_tready;
    assign row_ok     = (int'(row_index) < ROWS);

    // Stored levels of every row; each row register is selected by a compare.
    logic [LANES-1:0] levels_reg  [ROWS];
    logic [LANES-1:0] levels_next [ROWS];
    logic [LANES-1:0] before_levels;

    always_comb
    begin
        before_levels = '0;
        for (int r = 0; r < ROWS; r++)
        begin
            levels_next[r] = levels_reg[r];
            if (int'(row_index) == r)
            begin
                before_levels = levels_reg[r];
                if (accept)
                begin
                    levels_next[r] = now_levels;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < ROWS; r++)
            begin
                levels_reg[r] <= '0;
            end
        end
        else
        begin
            for (int r = 0; r < ROWS; r++)
            begin
                levels_reg[r] <= levels_next[r];
            end
        end
    end

    // Column lanes work side by side on one sample.
    kmcd_lane_ctrl_t  lane_ctrl;
    logic [LANES-1:0] lane_emit;
    logic [LANES-1:0] lane_press;

    assign lane_ctrl = '{pressed_level: pressed_level_reg,
                         press_on:      press_on_reg,
                         release_on:    release_on_reg};

    for (genvar c = 0; c < LANES; c++)
    begin : g_lane
        kmcd_lane u_lane
        (
            .prev_level (before_levels[c]),
            .now        (now_levels[c]),
            .ctrl       (lane_ctrl),
            .emit       (lane_emit[c]),
            .press      (lane_press[c])
        );
    end

    // A primed or out-of-range sample hands no events to the merging stage.
    logic             load;
    logic [LANES-1:0] load_mask;

    assign load      = accept && row_ok && !prime;
    assign load_mask = lane_emit;

    kmcd_merge #(
        .LANES (LANES)
    ) u_merge
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (load),
        .load_row   (row_index),
        .load_mask  (load_mask),
        .load_press (lane_press),
        .side       (side_reg),
        .busy       (busy),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule

### hdl/kmcd_lane.sv
// One column lane: detects a level change and classifies it as press or release.
`timescale 1ns / 1ps

module kmcd_lane
    import kmcd_pkg::*;
(
    input  logic            prev_level,
    input  logic            now,
    input  kmcd_lane_ctrl_t ctrl,
    output logic            emit,
    output logic            press
);

    logic changed;

    always_comb
    begin
        changed = prev_level ^ now;
        press   = (now == ctrl.pressed_level);
        emit    = changed & (press ? ctrl.press_on : ctrl.release_on);
    end

endmodule

### hdl/kmcd_merge.sv
// Merging stage: emits the lanes' events one per cycle while m_tready allows, in ascending column order.
`timescale 1ns / 1ps

module kmcd_merge
    import kmcd_pkg::*;
#(
    parameter int LANES = DEF_COLS
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  logic [ROW_W-1:0] load_row,
    input  logic [LANES-1:0] load_mask,
    input  logic [LANES-1:0] load_press,
    input  logic             side,
    output logic             busy,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [7:0]       m_tdata,   // event_row[2:0], event_column[6:3], event_side[7]
    output logic             m_tuser,   // is_press
    output logic             m_tlast
);

    logic [LANES-1:0] pend_reg;
    logic [LANES-1:0] pend_next;
    logic [LANES-1:0] press_reg;
    logic [LANES-1:0] press_next;
    logic [ROW_W-1:0] row_reg;
    logic [ROW_W-1:0] row_next;
    logic             valid_reg;
    logic             valid_next;
    logic [7:0]       data_reg;
    logic [7:0]       data_next;
    logic             press_out_reg;
    logic             press_out_next;
    logic             last_reg;
    logic             last_next;

    logic [COL_W-1:0] low_idx;
    logic             low_press;
    logic [LANES-1:0] pend_rest;
    logic             take;

    // Lowest pending column and its classification.
    always_comb
    begin
        low_idx   = '0;
        low_press = 1'b0;
        for (int c = LANES - 1; c >= 0; c--)
        begin
            if (pend_reg[c])
            begin
                low_idx   = COL_W'(c);
                low_press = press_reg[c];
            end
        end
    end

    always_comb
    begin
        pend_rest      = pend_reg & (pend_reg - LANES'(1));
        take           = (pend_reg != '0) && (!valid_reg || m_tready);

        pend_next      = pend_reg;
        press_next     = press_reg;
        row_next       = row_reg;
        valid_next     = valid_reg;
        data_next      = data_reg;
        press_out_next = press_out_reg;
        last_next      = last_reg;

        if (load)
        begin
            pend_next  = load_mask;
            press_next = load_press;
            row_next   = load_row;
        end
        else if (take)
        begin
            pend_next = pend_rest;
        end

        if (take)
        begin
            valid_next     = 1'b1;
            data_next      = {side, low_idx, row_reg};
            press_out_next = low_press;
            last_next      = (pend_rest == '0);
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            pend_reg  <= pend_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        press_reg     <= press_next;
        row_reg       <= row_next;
        data_reg      <= data_next;
        press_out_reg <= press_out_next;
        last_reg      <= last_next;
    end

    assign busy     = (pend_reg != '0);
    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = press_out_reg;
    assign m_tlast  = last_reg;

endmodule
